// ----- hw/rtl/bma_pkg.sv -----
package bma_pkg;

    localparam int ADDR_W   = 28;
    localparam int NEED_W   = ADDR_W + 1;
    localparam int BBL_W    = 5;
    localparam int HDR_W    = 7;
    localparam int STATUS_W = 2;
    localparam int GLEVEL_W = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [BBL_W-1:0] BBL_RESET = 5'd7;
    localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;

    localparam logic REG_BBL = 1'b0;
    localparam logic REG_HDR = 1'b1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SHIFT,
        S_A_LOG,
        S_A_PICK,
        S_A_DESC,
        S_A_SPL_L,
        S_A_SPL_R,
        S_A_UP,
        S_A_DONE,
        S_F_BLK,
        S_F_LVL,
        S_F_CHK,
        S_F_DEC,
        S_F_CLR,
        S_F_ROOT
    } t_state;

endpackage

// ----- hw/rtl/bma_ram.sv -----
module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// ----- hw/rtl/buddy_memory_allocator.sv -----
// Allocate: the result is a granted block, or the status too large or no free block.
// Free: marks the block free and merges buddies on the way up to the root;
//   a bad address ends the item with no change to the memory. One item is in work at a time.
// After reset the mask memory is swept, busy held high.
// The result word shows for one cycle on o_result_valid; the receiver cannot stall it.
module buddy_memory_allocator #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [bma_pkg::ADDR_W-1:0]          i_request_bytes,
    input  logic [bma_pkg::ADDR_W-1:0]          i_data_address,
    output logic                                o_result_valid,
    output logic [bma_pkg::STATUS_W-1:0]        o_status,
    output logic [bma_pkg::ADDR_W-1:0]          o_granted_address,
    output logic [bma_pkg::GLEVEL_W-1:0]        o_granted_level,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bma_pkg::APB_AW-1:0]          paddr,
    input  logic [bma_pkg::APB_DW-1:0]          pwdata,
    output logic [bma_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import bma_pkg::*;

    localparam int TOP = $clog2(NUM_BLOCKS + 1) - 1;
    localparam int MB  = 1 << TOP;
    localparam int NN  = 2 * MB;
    localparam int NW  = TOP + 1;
    localparam int MW  = TOP + 1;
    localparam int LW  = $clog2(TOP + 1);
    localparam int BW  = TOP;

    // control
    t_state             r_state, n_state;
    logic [NW-1:0]      r_clr, n_clr;
    logic               r_out_vld, n_out_vld;
    logic [BBL_W-1:0]   r_bbl;
    logic [HDR_W-1:0]   r_hdr;

    // work registers
    logic [NEED_W-1:0]  r_need, n_need;
    logic [NEED_W-1:0]  r_val, n_val;
    logic [NEED_W-1:0]  r_off, n_off;
    logic [LW-1:0]      r_want, n_want;
    logic [LW-1:0]      r_L, n_L;
    logic [LW-1:0]      r_lv, n_lv;
    logic [NW-1:0]      r_n, n_n;
    logic [NW-1:0]      r_f, n_f;
    logic [NW-1:0]      r_t, n_t;
    logic [MW-1:0]      r_v, n_v;
    logic               r_merge, n_merge;
    logic [BW-1:0]      r_blk, n_blk;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0]  r_gaddr, n_gaddr;
    logic [GLEVEL_W-1:0] r_glevel, n_glevel;

    // memories
    logic               m_we;
    logic [NW-1:0]      m_wa, m_ra, m_rb;
    logic [MW-1:0]      m_wd, m_qa, m_qb;
    logic               l_we;
    logic [BW-1:0]      l_wa, l_ra;
    logic [LW-1:0]      l_wd, l_q, l_qb;

    // helpers
    logic [NEED_W-1:0]  q_need;
    logic [ADDR_W-1:0]  blk_full;
    logic [MW-1:0]      pick_vec;
    logic               pick_found;
    logic [LW-1:0]      pick_lv;
    logic [NW-1:0]      child;
    logic [NW-1:0]      parent;
    logic [NW-1:0]      tnode;
    logic [BW-1:0]      start_blk;

    bma_ram #(.WIDTH(MW), .DEPTH(NN)) u_mask_ram (
        .i_clk     (i_clk),
        .i_we      (m_we),
        .i_waddr   (m_wa),
        .i_wdata   (m_wd),
        .i_raddr_a (m_ra),
        .o_rdata_a (m_qa),
        .i_raddr_b (m_rb),
        .o_rdata_b (m_qb)
    );

    bma_ram #(.WIDTH(LW), .DEPTH(MB)) u_level_ram (
        .i_clk     (i_clk),
        .i_we      (l_we),
        .i_waddr   (l_wa),
        .i_wdata   (l_wd),
        .i_raddr_a (l_ra),
        .o_rdata_a (l_q),
        .i_raddr_b (l_ra),
        .o_rdata_b (l_qb)
    );

    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HDR) ? APB_DW'(r_hdr) : APB_DW'(r_bbl);

    assign o_result_valid    = r_out_vld;
    assign o_status          = r_status;
    assign o_granted_address = r_gaddr;
    assign o_granted_level   = r_glevel;

    assign q_need   = r_need >> r_bbl;
    assign blk_full = r_off[ADDR_W-1:0] >> r_bbl;
    assign pick_vec = m_qa & ~((MW'(1) << r_want) - MW'(1));
    assign child    = {r_n[NW-2:0], ~m_qa[r_L]};
    assign parent   = r_n >> 1;
    assign tnode    = r_t - (NW'(1) << (TOP - int'(r_want)));
    assign start_blk = BW'(tnode << r_want);

    // lowest free level at or above the wanted one
    always_comb begin
        pick_found = 1'b0;
        pick_lv    = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (pick_vec[i]) begin
                pick_found = 1'b1;
                pick_lv    = LW'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_out_vld = 1'b0;
        n_need    = r_need;
        n_val     = r_val;
        n_off     = r_off;
        n_want    = r_want;
        n_L       = r_L;
        n_lv      = r_lv;
        n_n       = r_n;
        n_f       = r_f;
        n_t       = r_t;
        n_v       = r_v;
        n_merge   = r_merge;
        n_blk     = r_blk;
        n_status  = r_status;
        n_gaddr   = r_gaddr;
        n_glevel  = r_glevel;
        m_we      = 1'b0;
        m_wa      = r_n;
        m_wd      = '0;
        m_ra      = '0;
        m_rb      = '0;
        l_we      = 1'b0;
        l_wa      = start_blk;
        l_wd      = r_want;
        l_ra      = blk_full[BW-1:0];

        case (r_state)
            S_CLEAR: begin
                m_we = 1'b1;
                m_wa = r_clr;
                m_wd = (r_clr == NW'(1)) ? (MW'(1) << TOP) : '0;
                n_clr = r_clr + NW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_status = STATUS_OK;
                n_gaddr  = '0;
                n_glevel = '0;
                if (start) begin
                    n_need = NEED_W'(i_request_bytes) + NEED_W'(r_hdr);
                    n_off  = NEED_W'(i_data_address) - NEED_W'(r_hdr);
                    n_state = (i_func == FUNC_FREE) ? S_F_BLK : S_A_SHIFT;
                end
            end
            S_A_SHIFT: begin
                if ((q_need >> TOP) != '0) begin
                    n_status  = STATUS_TOO_LARGE;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_val   = (r_need == '0) ? '0 : ((r_need - NEED_W'(1)) >> r_bbl);
                    n_want  = '0;
                    n_state = S_A_LOG;
                end
            end
            S_A_LOG: begin
                if (r_val == '0) begin
                    m_ra    = NW'(1);
                    n_state = S_A_PICK;
                end else begin
                    n_val  = r_val >> 1;
                    n_want = r_want + LW'(1);
                end
            end
            S_A_PICK: begin
                if (!pick_found) begin
                    n_status  = STATUS_NO_FREE;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_L = pick_lv;
                    n_v = ((MW'(1) << pick_lv) - MW'(1)) & ~((MW'(1) << r_want) - MW'(1));
                    n_n = NW'(1);
                    if (pick_lv == LW'(TOP)) begin
                        n_f     = NW'(1);
                        n_lv    = pick_lv;
                        n_state = S_A_SPL_L;
                    end else begin
                        n_lv    = LW'(TOP);
                        m_ra    = NW'(2);
                        m_rb    = NW'(3);
                        n_state = S_A_DESC;
                    end
                end
            end
            S_A_DESC: begin
                // go left when the left child holds a block of the chosen level
                n_n = child;
                if (r_lv - LW'(1) == r_L) begin
                    n_f     = child;
                    n_lv    = r_L;
                    n_state = S_A_SPL_L;
                end else begin
                    n_lv = r_lv - LW'(1);
                    m_ra = {child[NW-2:0], 1'b0};
                    m_rb = {child[NW-2:0], 1'b1};
                end
            end
            S_A_SPL_L: begin
                m_we = 1'b1;
                m_wa = r_n;
                m_wd = ((MW'(1) << r_lv) - MW'(1)) & ~((MW'(1) << r_want) - MW'(1));
                if (r_lv == r_want) begin
                    n_t = r_n;
                    n_n = r_f;
                    if (r_f == NW'(1)) begin
                        n_state = S_A_DONE;
                    end else begin
                        m_ra    = r_f ^ NW'(1);
                        n_state = S_A_UP;
                    end
                end else begin
                    n_state = S_A_SPL_R;
                end
            end
            S_A_SPL_R: begin
                // free the upper half
                m_we    = 1'b1;
                m_wa    = {r_n[NW-2:0], 1'b1};
                m_wd    = MW'(1) << (r_lv - LW'(1));
                n_n     = {r_n[NW-2:0], 1'b0};
                n_lv    = r_lv - LW'(1);
                n_state = S_A_SPL_L;
            end
            S_A_UP: begin
                m_we = 1'b1;
                m_wa = parent;
                m_wd = r_v | m_qa;
                n_v  = r_v | m_qa;
                n_n  = parent;
                if (parent == NW'(1)) begin
                    n_state = S_A_DONE;
                end else begin
                    m_ra = parent ^ NW'(1);
                end
            end
            S_A_DONE: begin
                l_we      = 1'b1;
                n_status  = STATUS_OK;
                n_gaddr   = (ADDR_W'(start_blk) << r_bbl) + ADDR_W'(r_hdr);
                n_glevel  = GLEVEL_W'(r_want);
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            S_F_BLK: begin
                if (r_off[ADDR_W] ||
                    ((r_off[ADDR_W-1:0] & ~({ADDR_W{1'b1}} << r_bbl)) != '0) ||
                    ((blk_full >> TOP) != '0)) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_blk   = blk_full[BW-1:0];
                    n_state = S_F_LVL;
                end
            end
            S_F_LVL: begin
                if ((l_q > LW'(TOP)) || ((r_blk & ((BW'(1) << l_q) - BW'(1))) != '0)) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_n     = (NW'(1) << (TOP - int'(l_q))) | NW'(r_blk >> l_q);
                    n_f     = n_n;
                    n_lv    = l_q;
                    n_L     = l_q;
                    m_ra    = n_n;
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                // drop the free when the block or an ancestor is already free
                if (m_qa[r_lv]) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_n == NW'(1)) begin
                    n_n     = r_f;
                    n_lv    = r_L;
                    n_v     = MW'(1) << r_L;
                    n_merge = 1'b1;
                    if (r_f == NW'(1)) begin
                        n_state = S_F_ROOT;
                    end else begin
                        m_ra    = r_f ^ NW'(1);
                        n_state = S_F_DEC;
                    end
                end else begin
                    m_ra = parent;
                    n_n  = parent;
                    n_lv = r_lv + LW'(1);
                end
            end
            S_F_DEC: begin
                if (r_merge && m_qa[r_lv]) begin
                    m_we    = 1'b1;
                    m_wa    = r_n ^ NW'(1);
                    m_wd    = '0;
                    n_state = S_F_CLR;
                end else begin
                    m_we    = 1'b1;
                    m_wa    = r_n;
                    m_wd    = r_v;
                    n_v     = r_v | m_qa;
                    n_merge = 1'b0;
                    n_n     = parent;
                    n_lv    = r_lv + LW'(1);
                    if (parent == NW'(1)) begin
                        n_state = S_F_ROOT;
                    end else begin
                        m_ra    = parent ^ NW'(1);
                        n_state = S_F_DEC;
                    end
                end
            end
            S_F_CLR: begin
                m_we = 1'b1;
                m_wa = r_n;
                m_wd = '0;
                n_n  = parent;
                n_lv = r_lv + LW'(1);
                n_v  = MW'(1) << (r_lv + LW'(1));
                if (parent == NW'(1)) begin
                    n_state = S_F_ROOT;
                end else begin
                    m_ra    = parent ^ NW'(1);
                    n_state = S_F_DEC;
                end
            end
            S_F_ROOT: begin
                m_we      = 1'b1;
                m_wa      = NW'(1);
                m_wd      = r_v;
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
            r_bbl     <= BBL_RESET;
            r_hdr     <= HDR_RESET;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
            if (psel && penable && pwrite) begin
                case (paddr[2])
                    REG_BBL: r_bbl <= pwdata[BBL_W-1:0];
                    REG_HDR: r_hdr <= pwdata[HDR_W-1:0];
                    default: r_bbl <= r_bbl;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need   <= n_need;
        r_val    <= n_val;
        r_off    <= n_off;
        r_want   <= n_want;
        r_L      <= n_L;
        r_lv     <= n_lv;
        r_n      <= n_n;
        r_f      <= n_f;
        r_t      <= n_t;
        r_v      <= n_v;
        r_merge  <= n_merge;
        r_blk    <= n_blk;
        r_status <= n_status;
        r_gaddr  <= n_gaddr;
        r_glevel <= n_glevel;
    end

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result word shown while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != STATUS_OK) |->
        (o_granted_address == '0 && o_granted_level == '0))
        else $error("failed request carries an address");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_we && r_state != S_CLEAR) |-> (m_wa != m_ra))
        else $error("mask memory read and write hit the same node");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule
